/* rtl/xmc_pkg.sv */
// Shared types and constants for the x86 micro-op cracker.
package xmc_pkg;

  localparam int unsigned NumSlots = 8;
  localparam logic [63:0] TempAddr = 64'd32;
  localparam logic [63:0] TempLoad = 64'd33;
  localparam logic [63:0] RegSp = 64'd4;

  typedef enum logic [3:0] {
    OP_SUB = 4'd0, OP_ADD = 4'd1, OP_SUB_F = 4'd2, OP_ADD_F = 4'd3, OP_CMP = 4'd4,
    OP_TEST = 4'd5, OP_MULT = 4'd6, OP_DIV = 4'd7, OP_MOV = 4'd8, OP_JMP = 4'd9
  } op_code_e;

  typedef enum logic [1:0] {
    OT_IMM = 2'd0, OT_REG = 2'd1, OT_MEM = 2'd2, OT_NONE = 2'd3
  } opnd_e;

  typedef enum logic [2:0] {
    IT_ABSENT = 3'd0, IT_REG = 3'd1, IT_IMM = 3'd2, IT_MEM = 3'd3, IT_UNSUP = 3'd4
  } in_type_e;

  typedef enum logic [3:0] {
    K_SUB = 4'd0, K_ADD = 4'd1, K_MOV = 4'd2, K_CMP = 4'd3, K_TEST = 4'd4,
    K_PUSH16 = 4'd5, K_PUSH64 = 4'd6, K_JMP = 4'd7, K_CALL = 4'd8
  } kind_e;

  localparam logic [4:0] BaseRip = 5'd17;

  // Program slots of one instruction, emitted in this order.
  typedef enum logic [2:0] {
    S_ADDR_MOV = 3'd0, S_MULT = 3'd1, S_ADD_BASE = 3'd2, S_ADD_DISP = 3'd3,
    S_LOAD = 3'd4, S_SUB_SP = 3'd5, S_STORE = 3'd6, S_MAIN = 3'd7
  } slot_e;

  typedef struct packed {
    logic [3:0]        kind;
    logic [63:0]       rip;
    logic [3:0]        length;
    logic [2:0]        first_type;
    logic [63:0]       first_value;
    logic [2:0]        second_type;
    logic [63:0]       second_value;
    logic [4:0]        mem_base;
    logic [4:0]        mem_index;
    logic [3:0]        mem_scale;
    logic signed [63:0] mem_disp;
    logic [5:0]        flags_mask;
  } in_t;

  typedef struct packed {
    op_code_e    op_code;
    opnd_e       dest_type;
    logic [63:0] dest_value;
    opnd_e       src_type;
    logic [63:0] src_value;
    logic [5:0]  flags_wr;
    logic [63:0] path_a;
    logic [63:0] path_b;
    logic        failed;
    logic        last;
  } out_t;

  // Classified instruction, handed from front to back.
  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic        fail;
    op_code_e    main_code;
    opnd_e       main_dt;
    logic [63:0] main_dv;
    opnd_e       main_st;
    logic [63:0] main_sv;
    logic [5:0]  flags;
    opnd_e       addr_st;
    logic [63:0] addr_sv;
    logic [3:0]  scale;
    logic [4:0]  base;
    logic [63:0] disp;
    opnd_e       store_st;
    logic [63:0] store_sv;
    logic [3:0]  sp_bytes;
    logic [63:0] path_a;
    logic [63:0] path_b;
  } plan_t;

endpackage

/* rtl/xmc_front.sv */
// Front end: classifies one instruction into a slot plan.
module xmc_front (
  input  xmc_pkg::in_t   in_i,
  output xmc_pkg::plan_t plan_o
);
  import xmc_pkg::*;

  logic        is_alu, is_push, is_br, is_call;
  logic        op1_ok, op2_ok, use_mem, has_base, has_index, abs_form, fail;
  logic [63:0] ret_addr, rel_abs, br_target;
  opnd_e       t1_map, t2_map;
  op_code_e    alu_code;

  always_comb begin
    is_alu  = in_i.kind <= K_TEST;
    is_push = (in_i.kind == K_PUSH16) || (in_i.kind == K_PUSH64);
    is_call = in_i.kind == K_CALL;
    is_br   = (in_i.kind == K_JMP) || is_call;

    op1_ok = ((in_i.first_type == IT_REG) && (in_i.first_value[63:4] == '0)) ||
             (in_i.first_type == IT_IMM) || (in_i.first_type == IT_MEM);
    op2_ok = ((in_i.second_type == IT_REG) && (in_i.second_value[63:4] == '0)) ||
             (in_i.second_type == IT_IMM) || (in_i.second_type == IT_MEM);

    priority if (is_alu) begin
      fail = !op1_ok || !op2_ok ||
             ((in_i.first_type == IT_MEM) && (in_i.second_type == IT_MEM));
    end else if (is_push || is_br) begin
      fail = !op1_ok;
    end else begin
      fail = 1'b1;
    end

    use_mem = (in_i.first_type == IT_MEM) || (is_alu && (in_i.second_type == IT_MEM));
    has_base  = in_i.mem_base < 5'd16;
    has_index = in_i.mem_index < 5'd16;
    abs_form  = (in_i.mem_base == BaseRip) || (!has_base && !has_index);

    ret_addr  = in_i.rip + {60'd0, in_i.length};
    rel_abs   = ret_addr + in_i.mem_disp;
    br_target = ret_addr + in_i.first_value;

    unique case (in_i.first_type)
      IT_REG:  t1_map = OT_REG;
      IT_IMM:  t1_map = OT_IMM;
      default: t1_map = OT_MEM;
    endcase
    unique case (in_i.second_type)
      IT_REG:  t2_map = OT_REG;
      IT_IMM:  t2_map = OT_IMM;
      default: t2_map = OT_MEM;
    endcase

    unique case (in_i.kind)
      K_SUB:   alu_code = OP_SUB_F;
      K_ADD:   alu_code = OP_ADD_F;
      K_MOV:   alu_code = OP_MOV;
      K_CMP:   alu_code = OP_CMP;
      default: alu_code = OP_TEST;
    endcase

    plan_o = '0;
    plan_o.fail  = fail;
    plan_o.scale = in_i.mem_scale;
    plan_o.base  = in_i.mem_base;
    plan_o.disp  = in_i.mem_disp;
    plan_o.sp_bytes = (in_i.kind == K_PUSH16) ? 4'd2 : 4'd8;

    // Address expansion source
    if (abs_form) begin
      plan_o.addr_st = OT_IMM;
      plan_o.addr_sv = (in_i.mem_base == BaseRip) ? rel_abs : in_i.mem_disp;
    end else begin
      plan_o.addr_st = OT_REG;
      plan_o.addr_sv = has_index ? {59'd0, in_i.mem_index} : {59'd0, in_i.mem_base};
    end

    plan_o.mask[S_ADDR_MOV] = use_mem;
    plan_o.mask[S_MULT]     = use_mem && !abs_form && has_index && (in_i.mem_scale > 4'd1);
    plan_o.mask[S_ADD_BASE] = use_mem && !abs_form && has_index && has_base;
    plan_o.mask[S_ADD_DISP] = use_mem && !abs_form && (in_i.mem_disp != '0);
    plan_o.mask[S_LOAD]     = use_mem && !is_alu;
    plan_o.mask[S_SUB_SP]   = is_push || is_call;
    plan_o.mask[S_STORE]    = is_push || is_call;
    plan_o.mask[S_MAIN]     = is_alu || is_br;

    // Store source for push or call
    if (is_call) begin
      plan_o.store_st = OT_IMM;
      plan_o.store_sv = ret_addr;
    end else if (in_i.first_type == IT_MEM) begin
      plan_o.store_st = OT_REG;
      plan_o.store_sv = TempLoad;
    end else begin
      plan_o.store_st = t1_map;
      plan_o.store_sv = in_i.first_value;
    end

    plan_o.path_a = ret_addr;
    if (is_alu) begin
      plan_o.main_code = alu_code;
      plan_o.main_dt   = t1_map;
      plan_o.main_dv   = (in_i.first_type == IT_MEM) ? TempAddr : in_i.first_value;
      plan_o.main_st   = t2_map;
      plan_o.main_sv   = (in_i.second_type == IT_MEM) ? TempAddr : in_i.second_value;
      plan_o.flags     = (in_i.kind == K_MOV) ? 6'd0 : in_i.flags_mask;
    end else begin
      plan_o.main_code = OP_JMP;
      plan_o.main_st   = OT_NONE;
      plan_o.main_sv   = '0;
      if (in_i.first_type == IT_IMM) begin
        plan_o.main_dt = OT_IMM;
        plan_o.main_dv = br_target;
      end else begin
        plan_o.main_dt = OT_REG;
        plan_o.main_dv = (in_i.first_type == IT_MEM) ? TempLoad : in_i.first_value;
      end
      if (is_br) begin
        plan_o.path_a = (in_i.first_type == IT_IMM) ? br_target : '0;
        plan_o.path_b = is_call ? ret_addr : '0;
      end
    end

    if (fail) begin
      plan_o.mask = '0;
      plan_o.mask[S_MAIN] = 1'b1;
    end
  end

endmodule

/* rtl/xmc_queue.sv */
// Small register queue of slot plans between front and back.
module xmc_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xmc_pkg::plan_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output xmc_pkg::plan_t data_o
);
  import xmc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  plan_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o || pop_i)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

/* rtl/xmc_back.sv */
// Back end: walks the slot plan and emits one micro-op per cycle while the output is not stalled.
module xmc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  xmc_pkg::plan_t plan_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output xmc_pkg::out_t  out_data_o
);
  import xmc_pkg::*;

  logic [NumSlots-1:0] done_q, done_d, rem, rest;
  logic [2:0]          idx;
  logic                fire, is_last, out_valid_q, out_valid_d;
  out_t                op, out_q;

  assign rem  = plan_i.mask & ~done_q;
  assign fire = !empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    idx = S_MAIN;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (rem[i]) begin
        idx = 3'(i);
      end
    end
    rest    = rem;
    rest[idx] = 1'b0;
    is_last = rest == '0;
  end

  always_comb begin
    op = '0;
    op.path_a    = plan_i.path_a;
    op.path_b    = plan_i.path_b;
    op.last      = is_last;
    op.dest_type = OT_REG;
    op.dest_value = TempAddr;
    unique case (slot_e'(idx))
      S_ADDR_MOV: begin
        op.op_code = OP_MOV;
        op.src_type = plan_i.addr_st;
        op.src_value = plan_i.addr_sv;
      end
      S_MULT: begin
        op.op_code = OP_MULT;
        op.src_type = OT_IMM;
        op.src_value = {60'd0, plan_i.scale};
      end
      S_ADD_BASE: begin
        op.op_code = OP_ADD;
        op.src_type = OT_REG;
        op.src_value = {59'd0, plan_i.base};
      end
      S_ADD_DISP: begin
        op.op_code = OP_ADD;
        op.src_type = OT_IMM;
        op.src_value = plan_i.disp;
      end
      S_LOAD: begin
        op.op_code = OP_MOV;
        op.dest_value = TempLoad;
        op.src_type = OT_MEM;
        op.src_value = TempAddr;
      end
      S_SUB_SP: begin
        op.op_code = OP_SUB;
        op.dest_value = RegSp;
        op.src_type = OT_IMM;
        op.src_value = {60'd0, plan_i.sp_bytes};
      end
      S_STORE: begin
        op.op_code = OP_MOV;
        op.dest_type = OT_MEM;
        op.dest_value = RegSp;
        op.src_type = plan_i.store_st;
        op.src_value = plan_i.store_sv;
      end
      default: begin
        if (plan_i.fail) begin
          // failure: single record, everything else zero
          op = '0;
          op.dest_type = OT_NONE;
          op.src_type  = OT_NONE;
          op.failed    = 1'b1;
          op.last      = 1'b1;
        end else begin
          op.op_code = plan_i.main_code;
          op.dest_type = plan_i.main_dt;
          op.dest_value = plan_i.main_dv;
          op.src_type = plan_i.main_st;
          op.src_value = plan_i.main_sv;
          op.flags_wr = plan_i.flags;
        end
      end
    endcase
  end

  always_comb begin
    done_d = done_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      out_valid_d = 1'b1;
      done_d = is_last ? '0 : (done_q | ~rest & rem);
    end
  end

  assign pop_o = fire && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= op;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fire |-> rem != '0)
    else $error("emit with empty slot plan");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.failed |-> out_data_o.last)
    else $error("failure record not last");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_i |=> $stable(done_q))
    else $error("slot progress without a plan");

endmodule

/* rtl/x86_to_micro_op_cracker_core.sv */
// Top level of the x86 instruction to micro-op cracker.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one decoded
// instruction per transaction. Output channel (out_valid_o / out_stall_i /
// out_data_o) gives one micro-op per transaction; out_data_o.last marks the
// final micro-op of an instruction, and an unliftable form gives a single
// transaction with failed and last set.
// The front classifies an instruction in the cycle it arrives and writes a
// slot plan into a short queue (QueueDepth entries). The back walks the eight
// program slots (address build, load, stack adjust, store, main op) and
// emits one micro-op per cycle into an output register while the output is
// not stalled. The first micro-op passes through the queue and then the
// output register before it is visible. An instruction gives 1 to 8
// micro-ops, and the back end has a single output register; acceptance
// continues while the queue has room.
// Reset empties the queue and clears output valid; no clearing pass is needed.
// A stalled output holds its transaction; the back stops, the queue fills,
// and in_stall_o rises once the queue is full.
module x86_to_micro_op_cracker_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  xmc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output xmc_pkg::out_t  out_data_o
);
  import xmc_pkg::*;

  plan_t plan_front, plan_head;
  logic  q_full, q_empty, q_pop, in_fire;

  assign in_stall_o = q_full;
  assign in_fire    = in_valid_i && !q_full;

  xmc_front u_front (
    .in_i   (in_data_i),
    .plan_o (plan_front)
  );

  xmc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire),
    .data_i  (plan_front),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (plan_head)
  );

  xmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .plan_i      (plan_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
